[hdl/mfhs_pkg.sv]
// Shared types and constants for the motor fader hold-off scheduler.
`default_nettype none
package mfhs_pkg;

  localparam int NUM_FADERS_DEF = 13;
  localparam int POS_W          = 12;
  localparam int HOLD_W         = 8;
  localparam int FIDX_W         = 4;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd10;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_MOVED = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_target;  // store target at the addressed fader
    logic wr_moved;   // store target, driven position and hold-off
    logic step;       // process the walked entry
    logic clear;      // walk clears instead of ticking
    logic flush;      // deliver the held word as the final one
  } dp_cmd_t;

endpackage
`default_nettype wire

[hdl/motor_fader_holdoff_scheduler_unit.sv]
// Set and moved items are written straight away; busy stays low and the next item may follow at once.
// Tick and reset items walk one fader entry per cycle, then flush: busy is high through
// the walk and the flush, and the next item is accepted once busy has fallen again.
// Move words come out in fader order, one cycle each; a word leaves the cycle after the
// step that finds the next word, and the last one leaves the cycle after the flush.
// Synchronous rst clears targets, driven positions and hold-offs and loads hold_ticks to 10.
`default_nettype none
module motor_fader_holdoff_scheduler_unit #(
  parameter int NUM_FADERS = mfhs_pkg::NUM_FADERS_DEF,
  localparam int IDX_W = (NUM_FADERS > 1) ? $clog2(NUM_FADERS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    cmd,
  input  wire logic [mfhs_pkg::FIDX_W-1:0]   fader_index,
  input  wire logic [mfhs_pkg::POS_W-1:0]    position,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mfhs_pkg::HOLD_W-1:0]   cfg_data,
  output logic                               move_strobe,
  output logic [mfhs_pkg::FIDX_W-1:0]        move_index,
  output logic [mfhs_pkg::POS_W-1:0]         move_position,
  output logic                               last
);

  mfhs_pkg::dp_cmd_t dp_cmd;
  logic [IDX_W-1:0]  step_idx;

  assign cfg_ready = 1'b1;

  mfhs_ctrl #(.NUM_FADERS(NUM_FADERS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .fader_index (fader_index),
    .busy        (busy),
    .dp_cmd      (dp_cmd),
    .step_idx    (step_idx)
  );

  mfhs_dp #(.NUM_FADERS(NUM_FADERS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .step_idx      (step_idx),
    .fader_index   (fader_index),
    .position      (position),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .move_strobe   (move_strobe),
    .move_index    (move_index),
    .move_position (move_position),
    .last          (last)
  );

  // A move word only ever leaves as part of a walk.
  a_strobe_in_walk: assert property (@(posedge clk) disable iff (rst)
    move_strobe |-> $past(busy))
    else $error("move word outside a walk");

  a_walk_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == mfhs_pkg::CMD_TICK || cmd == mfhs_pkg::CMD_RESET)) |=> busy)
    else $error("tick or reset did not start a walk");

  a_update_single: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == mfhs_pkg::CMD_SET || cmd == mfhs_pkg::CMD_MOVED)) |=> !busy)
    else $error("set or moved item left the block busy");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (move_strobe && last) |=> !move_strobe)
    else $error("word after the final move word");

endmodule
`default_nettype wire

[hdl/mfhs_ctrl.sv]
// Controller: accepts items, walks the fader entries, closes each walk with a flush.
`default_nettype none
module mfhs_ctrl #(
  parameter int NUM_FADERS = mfhs_pkg::NUM_FADERS_DEF,
  localparam int IDX_W = (NUM_FADERS > 1) ? $clog2(NUM_FADERS) : 1,
  localparam int CNT_W = $clog2(NUM_FADERS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [1:0]                  cmd,
  input  wire logic [mfhs_pkg::FIDX_W-1:0] fader_index,
  output logic                             busy,
  output mfhs_pkg::dp_cmd_t                dp_cmd,
  output logic [IDX_W-1:0]                 step_idx
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             clear_op;
  logic             in_range;
  logic             accept;

  assign accept   = start && (state == ST_IDLE);
  assign in_range = ({28'b0, fader_index} < 32'(NUM_FADERS));
  assign busy     = (state != ST_IDLE);
  assign step_idx = cnt[IDX_W-1:0];

  always_comb begin
    dp_cmd           = '0;
    dp_cmd.wr_target = accept && in_range && (mfhs_pkg::cmd_t'(cmd) == mfhs_pkg::CMD_SET);
    dp_cmd.wr_moved  = accept && in_range && (mfhs_pkg::cmd_t'(cmd) == mfhs_pkg::CMD_MOVED);
    dp_cmd.step      = (state == ST_WALK);
    dp_cmd.clear     = clear_op;
    dp_cmd.flush     = (state == ST_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      clear_op <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept) begin
            unique case (mfhs_pkg::cmd_t'(cmd))
              mfhs_pkg::CMD_TICK: begin
                state    <= ST_WALK;
                clear_op <= 1'b0;
              end
              mfhs_pkg::CMD_RESET: begin
                state    <= ST_WALK;
                clear_op <= 1'b1;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_WALK: begin
          if (cnt == CNT_W'(NUM_FADERS - 1)) begin
            state <= ST_FLUSH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FLUSH: state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/mfhs_dp.sv]
// Datapath: per-fader state, hold-off register and one-word-deep move output holder.
`default_nettype none
module mfhs_dp #(
  parameter int NUM_FADERS = mfhs_pkg::NUM_FADERS_DEF,
  localparam int IDX_W = (NUM_FADERS > 1) ? $clog2(NUM_FADERS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mfhs_pkg::dp_cmd_t             dp_cmd,
  input  wire logic [IDX_W-1:0]              step_idx,
  input  wire logic [mfhs_pkg::FIDX_W-1:0]   fader_index,
  input  wire logic [mfhs_pkg::POS_W-1:0]    position,
  input  wire logic                          cfg_we,
  input  wire logic [mfhs_pkg::HOLD_W-1:0]   cfg_data,
  output logic                               move_strobe,
  output logic [mfhs_pkg::FIDX_W-1:0]        move_index,
  output logic [mfhs_pkg::POS_W-1:0]         move_position,
  output logic                               last
);

  logic [mfhs_pkg::POS_W-1:0]  target [NUM_FADERS];
  logic [mfhs_pkg::POS_W-1:0]  driven [NUM_FADERS];
  logic [mfhs_pkg::HOLD_W-1:0] holdoff [NUM_FADERS];
  logic [mfhs_pkg::HOLD_W-1:0] hold_ticks;

  logic                        pend_v;
  logic [IDX_W-1:0]            pend_idx;
  logic [mfhs_pkg::POS_W-1:0]  pend_pos;
  logic [IDX_W-1:0]            out_idx;

  logic [IDX_W+mfhs_pkg::FIDX_W-1:0] fi_ext;
  logic [IDX_W+mfhs_pkg::FIDX_W-1:0] oi_ext;
  logic [IDX_W-1:0]                  wr_idx;

  logic [mfhs_pkg::POS_W-1:0]  cur_target;
  logic [mfhs_pkg::POS_W-1:0]  cur_driven;
  logic [mfhs_pkg::HOLD_W-1:0] cur_hold;
  logic                        emit;
  logic [mfhs_pkg::POS_W-1:0]  emit_pos;

  assign fi_ext = (IDX_W + mfhs_pkg::FIDX_W)'(fader_index);
  assign wr_idx = fi_ext[IDX_W-1:0];
  assign oi_ext = (IDX_W + mfhs_pkg::FIDX_W)'(out_idx);
  assign move_index = oi_ext[mfhs_pkg::FIDX_W-1:0];

  assign cur_target = target[step_idx];
  assign cur_driven = driven[step_idx];
  assign cur_hold   = holdoff[step_idx];

  always_comb begin
    if (dp_cmd.clear) begin
      emit     = dp_cmd.step;
      emit_pos = '0;
    end else begin
      emit     = dp_cmd.step && (cur_hold == '0) && (cur_driven != cur_target);
      emit_pos = cur_target;
    end
  end

  // Fader state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FADERS; i++) begin
        target[i]  <= '0;
        driven[i]  <= '0;
        holdoff[i] <= '0;
      end
      hold_ticks <= mfhs_pkg::HOLD_RESET;
    end else begin
      if (cfg_we) begin
        hold_ticks <= cfg_data;
      end
      if (dp_cmd.wr_target) begin
        target[wr_idx] <= position;
      end
      if (dp_cmd.wr_moved) begin
        target[wr_idx]  <= position;
        driven[wr_idx]  <= position;
        holdoff[wr_idx] <= hold_ticks;
      end
      if (dp_cmd.step) begin
        if (dp_cmd.clear) begin
          holdoff[step_idx] <= '0;
          driven[step_idx]  <= '0;
        end else if (cur_hold != '0) begin
          holdoff[step_idx] <= cur_hold - 1'b1;
        end else begin
          driven[step_idx] <= cur_target;
        end
      end
    end
  end

  // Hold one move word back so the final one of a walk can carry last.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v      <= 1'b0;
      move_strobe <= 1'b0;
      last        <= 1'b0;
    end else begin
      move_strobe <= 1'b0;
      last        <= 1'b0;
      if (emit) begin
        move_strobe <= pend_v;
        pend_v      <= 1'b1;
      end else if (dp_cmd.flush) begin
        move_strobe <= pend_v;
        last        <= 1'b1;
        pend_v      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend_idx <= step_idx;
      pend_pos <= emit_pos;
    end
    if (emit || dp_cmd.flush) begin
      out_idx       <= pend_idx;
      move_position <= pend_pos;
    end
  end

endmodule
`default_nettype wire
